/* hdl/wdwr_pkg.sv */
// Shared types and constants for the weighted draw without replacement block.
// Used by wdwr_cell, wdwr_ctrl and weighted_draw_without_replacement.
// No dependencies.
package wdwr_pkg;

	// Default sizes of the ball table.
	localparam int MAX_BALLS_DEF   = 128;
	localparam int WEIGHT_BITS_DEF = 16;

	// Fixed field widths of the stream payloads.
	localparam int INDEX_W  = 7;
	localparam int LOAD_W   = 16;
	localparam int FRAC_W   = 16;
	localparam int NUMBER_W = 8;
	localparam int CFG_W    = 8;
	localparam int CFG_IDX_W = 1;

	// Item modes carried in tuser on the input side.
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_PICK = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_BALLS_IN_USE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PICKS_PER_DRAW = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [CFG_W-1:0] BALLS_IN_USE_RST  = 8'd90;
	localparam logic [CFG_W-1:0] PICKS_PER_DRAW_RST = 8'd6;

	// Control broadcast from the controller to every cell of the ring.
	typedef struct packed {
		logic shift;
		logic clear_used;
	} ring_ctl_t;

endpackage

/* hdl/wdwr_cell.sv */
// One cell of the ball ring: holds one weight and its used mark.
// Shifts its contents to the neighbor cell when the ring rotates.
// Depends on wdwr_pkg.
module wdwr_cell #(
	parameter int WEIGHT_BITS = wdwr_pkg::WEIGHT_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  wdwr_pkg::ring_ctl_t     ctl,
	input  logic                    load_en,
	input  logic [WEIGHT_BITS-1:0]  load_weight,
	input  logic [WEIGHT_BITS-1:0]  next_weight,
	input  logic                    next_used,
	output logic [WEIGHT_BITS-1:0]  weight,
	output logic                    used
);

	logic [WEIGHT_BITS-1:0] weight_q;
	logic                   used_q;

	// A load only happens while the ring is parked, so it never meets a shift.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= '0;
			used_q   <= 1'b0;
		end else begin
			if (load_en) begin
				weight_q <= load_weight;
			end else if (ctl.shift) begin
				weight_q <= next_weight;
			end
			if (ctl.clear_used) begin
				used_q <= 1'b0;
			end else if (ctl.shift) begin
				used_q <= next_used;
			end
		end
	end

	assign weight = weight_q;
	assign used   = used_q;

endmodule

/* hdl/wdwr_ctrl.sv */
// Controller at the head of the ball ring: sums, scales and scans the weights
// as they rotate past cell 0, and holds the result register.
// Depends on wdwr_pkg.
module wdwr_ctrl #(
	parameter int MAX_BALLS   = wdwr_pkg::MAX_BALLS_DEF,
	parameter int WEIGHT_BITS = wdwr_pkg::WEIGHT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input side
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              in_mode,
	input  logic [wdwr_pkg::FRAC_W-1:0]       in_frac,
	// Configuration
	input  logic [wdwr_pkg::CFG_W-1:0]        balls_in_use,
	input  logic [wdwr_pkg::CFG_W-1:0]        picks_per_draw,
	// Ring head
	input  logic [WEIGHT_BITS-1:0]            head_weight,
	input  logic                              head_used,
	output wdwr_pkg::ring_ctl_t               ring_ctl,
	output logic                              mark,
	// Output side
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [wdwr_pkg::NUMBER_W-1:0]     ball_number,
	output logic                              last_pick,
	output logic                              exhausted
);

	localparam int CNT_W  = $clog2(MAX_BALLS);
	localparam int SUM_W  = WEIGHT_BITS + $clog2(MAX_BALLS);
	localparam int PROD_W = SUM_W + wdwr_pkg::FRAC_W;
	localparam int BIT_W  = $clog2(wdwr_pkg::FRAC_W);
	localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(MAX_BALLS - 1);
	localparam logic [BIT_W-1:0] TOP_BIT  = BIT_W'(wdwr_pkg::FRAC_W - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_MULT,
		ST_SCAN,
		ST_EMIT
	} state_t;

	state_t                          state_q;
	logic [CNT_W-1:0]                pos_q;
	logic [BIT_W-1:0]                bit_q;
	logic [wdwr_pkg::FRAC_W-1:0]     frac_q;
	logic [SUM_W-1:0]                total_q;
	logic [PROD_W-1:0]               prod_q;
	logic [SUM_W-1:0]                cum_q;
	logic                            found_q;
	logic [CNT_W-1:0]                chosen_q;
	logic                            exh_q;
	logic [wdwr_pkg::CFG_W-1:0]      pick_q;
	logic                            out_valid_q;
	logic [wdwr_pkg::NUMBER_W-1:0]   ball_number_q;
	logic                            last_pick_q;
	logic                            exhausted_q;

	logic                            eligible;
	logic [SUM_W-1:0]                add_w;
	logic [SUM_W-1:0]                sum_next;
	logic [SUM_W-1:0]                cum_next;
	logic [SUM_W-1:0]                target;
	logic [PROD_W-1:0]               prod_next;
	logic [wdwr_pkg::CFG_W-1:0]      pick_next;
	logic                            draw_done;
	logic                            emit_fire;

	// The ball at cell 0 takes part when it is in range and not yet drawn.
	// The ring position never reaches MAX_BALLS, so no saturation is needed.
	assign eligible = (32'(pos_q) < 32'(balls_in_use)) && !head_used;
	assign add_w    = eligible ? SUM_W'(head_weight) : '0;
	assign sum_next = total_q + add_w;
	assign cum_next = cum_q + add_w;

	// Shift-and-add multiply, one fraction bit per cycle from the top down.
	assign prod_next = {prod_q[PROD_W-2:0], 1'b0}
		+ (frac_q[bit_q] ? PROD_W'(total_q) : '0);
	assign target    = prod_q[PROD_W-1:wdwr_pkg::FRAC_W];

	// First eligible ball whose running sum passes the target is drawn.
	assign mark = (state_q == ST_SCAN) && eligible && !found_q && (cum_next > target);

	// Draw bookkeeping when the result is written out.
	assign pick_next = pick_q + 8'd1;
	assign draw_done = exh_q || (pick_next >= picks_per_draw);
	assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	assign ring_ctl.shift      = (state_q == ST_SUM) || (state_q == ST_SCAN);
	assign ring_ctl.clear_used = emit_fire && draw_done;

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign ball_number = ball_number_q;
	assign last_pick   = last_pick_q;
	assign exhausted   = exhausted_q;

	// Sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			pos_q         <= '0;
			bit_q         <= '0;
			frac_q        <= '0;
			total_q       <= '0;
			prod_q        <= '0;
			cum_q         <= '0;
			found_q       <= 1'b0;
			chosen_q      <= '0;
			exh_q         <= 1'b0;
			pick_q        <= '0;
			out_valid_q   <= 1'b0;
			ball_number_q <= '0;
			last_pick_q   <= 1'b0;
			exhausted_q   <= 1'b0;
		end else begin
			// The result register fills on an emit and empties on an accepted transfer.
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && (in_mode == wdwr_pkg::MODE_PICK)) begin
						frac_q  <= in_frac;
						total_q <= '0;
						pos_q   <= '0;
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					total_q <= sum_next;
					pos_q   <= (pos_q == LAST_POS) ? '0 : pos_q + 1'b1;
					if (pos_q == LAST_POS) begin
						if (sum_next == '0) begin
							exh_q   <= 1'b1;
							state_q <= ST_EMIT;
						end else begin
							exh_q   <= 1'b0;
							prod_q  <= '0;
							bit_q   <= TOP_BIT;
							state_q <= ST_MULT;
						end
					end
				end
				ST_MULT: begin
					prod_q <= prod_next;
					bit_q  <= bit_q - 1'b1;
					if (bit_q == '0) begin
						cum_q   <= '0;
						found_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					cum_q <= cum_next;
					pos_q <= (pos_q == LAST_POS) ? '0 : pos_q + 1'b1;
					if (mark) begin
						found_q  <= 1'b1;
						chosen_q <= pos_q;
					end
					if (pos_q == LAST_POS) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_fire) begin
						exhausted_q <= exh_q;
						if (exh_q) begin
							ball_number_q <= '0;
							last_pick_q   <= 1'b0;
						end else begin
							ball_number_q <= wdwr_pkg::NUMBER_W'(int'(chosen_q) + 1);
							last_pick_q   <= draw_done;
						end
						pick_q  <= draw_done ? '0 : pick_next;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The ring is parked at its home position whenever it is not rotating.
	a_ring_home: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_MULT || state_q == ST_EMIT) |-> (pos_q == '0))
		else $error("ring not at home position outside a pass");

	// A nonzero total scaled by a fraction below one stays below the total.
	a_target_below_total: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && pos_q == '0) |-> (target < total_q))
		else $error("scan target not below total");

	// A completed scan always finds a ball.
	a_scan_finds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && !exh_q) |-> found_q)
		else $error("scan ended without a chosen ball");

	// A drawn ball number is zero exactly for an exhausted pick.
	a_number_vs_exhausted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((ball_number_q == '0) == exhausted_q))
		else $error("ball number and exhausted flag disagree");

	// Used marks are never cleared while the ring rotates.
	a_no_clear_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		ring_ctl.clear_used |-> !ring_ctl.shift)
		else $error("used marks cleared during a rotation");

endmodule

/* hdl/weighted_draw_without_replacement.sv */
// Top level: a ring of MAX_BALLS cells, each holding one weight and used mark.
// A load's weight is registered in its cell at its transfer. A pick's result is
// formed by one ring rotation to sum, then, unless the pick is exhausted, a
// bit-serial multiply over the 16 fraction bits and a second rotation to scan.
// One pick is in flight at a time. The next item can be taken the cycle after
// the result is registered, and a result waits to be registered while an earlier
// one waits on m_axis_tready; loads are taken whenever the block is idle.
// Reset clears all weights and used marks, the pick count and the result register.
// Depends on wdwr_pkg, wdwr_cell and wdwr_ctrl.
module weighted_draw_without_replacement #(
	parameter int MAX_BALLS   = wdwr_pkg::MAX_BALLS_DEF,
	parameter int WEIGHT_BITS = wdwr_pkg::WEIGHT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Input stream
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [39:0]                    s_axis_tdata,  // ball_index, weight, random_fraction
	input  logic                           s_axis_tuser,  // mode
	// Output stream
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [7:0]                     m_axis_tdata,  // ball_number
	output logic                           m_axis_tlast,  // last_pick
	output logic                           m_axis_tuser,  // exhausted
	// Configuration writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [wdwr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wdwr_pkg::CFG_W-1:0]     cfg_data
);

	localparam int IDX_LO    = 0;
	localparam int WEIGHT_LO = IDX_LO + wdwr_pkg::INDEX_W;
	localparam int FRAC_LO   = WEIGHT_LO + wdwr_pkg::LOAD_W;

	logic [wdwr_pkg::CFG_W-1:0]    balls_in_use_q;
	logic [wdwr_pkg::CFG_W-1:0]    picks_per_draw_q;
	logic [wdwr_pkg::INDEX_W-1:0]  load_index;
	logic [WEIGHT_BITS-1:0]        load_weight;
	logic                          load_fire;
	logic [MAX_BALLS-1:0]          load_en;
	logic [WEIGHT_BITS-1:0]        ring_weight [MAX_BALLS];
	logic                          ring_used   [MAX_BALLS];
	wdwr_pkg::ring_ctl_t           ring_ctl;
	logic                          mark;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			balls_in_use_q   <= wdwr_pkg::BALLS_IN_USE_RST;
			picks_per_draw_q <= wdwr_pkg::PICKS_PER_DRAW_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				wdwr_pkg::CFG_BALLS_IN_USE:   balls_in_use_q   <= cfg_data;
				wdwr_pkg::CFG_PICKS_PER_DRAW: picks_per_draw_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// A load transfer writes its cell directly; indexes past the ring are dropped.
	assign load_index  = s_axis_tdata[WEIGHT_LO-1:IDX_LO];
	assign load_weight = WEIGHT_BITS'(s_axis_tdata[FRAC_LO-1:WEIGHT_LO]);
	assign load_fire   = s_axis_tvalid && s_axis_tready
		&& (s_axis_tuser == wdwr_pkg::MODE_LOAD);

	// Ring of cells: each takes its neighbor's contents; the last one takes
	// cell 0, with the used mark set when the head draws that ball.
	for (genvar i = 0; i < MAX_BALLS; i++) begin : g_cell
		logic [WEIGHT_BITS-1:0] nxt_weight;
		logic                   nxt_used;

		assign load_en[i] = load_fire && (32'(load_index) == i);

		if (i == MAX_BALLS - 1) begin : g_wrap
			assign nxt_weight = ring_weight[0];
			assign nxt_used   = ring_used[0] | mark;
		end else begin : g_link
			assign nxt_weight = ring_weight[i+1];
			assign nxt_used   = ring_used[i+1];
		end

		wdwr_cell #(
			.WEIGHT_BITS(WEIGHT_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ring_ctl),
			.load_en     (load_en[i]),
			.load_weight (load_weight),
			.next_weight (nxt_weight),
			.next_used   (nxt_used),
			.weight      (ring_weight[i]),
			.used        (ring_used[i])
		);
	end

	// Head controller and result register.
	wdwr_ctrl #(
		.MAX_BALLS   (MAX_BALLS),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.in_mode        (s_axis_tuser),
		.in_frac        (s_axis_tdata[FRAC_LO+wdwr_pkg::FRAC_W-1:FRAC_LO]),
		.balls_in_use   (balls_in_use_q),
		.picks_per_draw (picks_per_draw_q),
		.head_weight    (ring_weight[0]),
		.head_used      (ring_used[0]),
		.ring_ctl       (ring_ctl),
		.mark           (mark),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.ball_number    (m_axis_tdata),
		.last_pick      (m_axis_tlast),
		.exhausted      (m_axis_tuser)
	);

endmodule
